@@ rtl/core/gis_pkg.sv @@
// Package for the greedy independent set selector.
// Holds the default sizes, field widths and the mode, status and mark codes.
// Depends on nothing.
`default_nettype none

package gis_pkg;

   localparam int MAX_VERTICES_DEFAULT = 1024;
   localparam int MAX_ENTRIES_DEFAULT  = 8192;

   localparam int MODE_W     = 2;
   localparam int POSITION_W = 13;
   localparam int VALUE_W    = 14;
   localparam int VERTEX_W   = 10;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 11;
   localparam int MARK_W     = 2;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;

   localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = COUNT_W'(1024);

   localparam logic [MODE_W-1:0] MODE_LOAD_ROW = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD_COL = 2'd1;
   localparam logic [MODE_W-1:0] MODE_VISIT    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd3;

   localparam logic [STATUS_W-1:0] ST_LOADED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MARKED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ISOLATED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NEIGHBOR = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SELECTED = 3'd4;
   localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;
   localparam logic [STATUS_W-1:0] ST_BAD      = 3'd6;

   localparam logic [MARK_W-1:0] MARK_NONE     = 2'd0;
   localparam logic [MARK_W-1:0] MARK_SELECTED = 2'd1;
   localparam logic [MARK_W-1:0] MARK_EXCLUDED = 2'd2;

endpackage

`default_nettype wire

@@ rtl/core/greedy_independent_set_selector.sv @@
// Greedy maximal independent set selector, top level and only module.
// Depends on gis_pkg for sizes and codes.
//
// Usage: transactions on the req channel carry a mode in req_tuser. Load modes write the
// row-start store or the column store of a graph in compressed-row form; a visit presents one
// vertex; a clear wipes all vertex marks and the selected count. Every transaction gives one
// response on the rsp channel with a status in rsp_tuser. The user must write the vertex count
// register through the csr channel only while the block is idle; the block does not enforce it.
// A load or a bad vertex goes straight to the response state. A visit reads the row bounds,
// then scans the row with a column read, a mark read and a test per entry and, if the vertex
// is selected, walks the row again with a column read and a mark write per entry to mark
// exclusions, all through memories with one read port and one write port each.
// A clear sweeps the mark memory one entry a cycle.
// One transaction is in work at a time; req_tready is low until it has finished.
// After reset the block sweeps the whole mark memory with req_tready low; csr writes are
// taken at all times. The response waits in an output register while the receiver stalls,
// and a new request may be accepted meanwhile.
`default_nettype none

module greedy_independent_set_selector #(
   parameter int MAX_VERTICES = gis_pkg::MAX_VERTICES_DEFAULT,
   parameter int MAX_ENTRIES  = gis_pkg::MAX_ENTRIES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // position [12:0], value [26:13], vertex [36:27], zero fill [39:37]
   input  wire logic [gis_pkg::REQ_DATA_W-1:0]    req_tdata,
   // mode [1:0]
   input  wire logic [gis_pkg::MODE_W-1:0]        req_tuser,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // vertex_out [9:0], selected_count [20:10], zero fill [23:21]
   output logic [gis_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // status [2:0]
   output logic [gis_pkg::STATUS_W-1:0]           rsp_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic [gis_pkg::COUNT_W-1:0]       csr_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready
);

   localparam int VAW = $clog2(MAX_VERTICES);
   localparam int RAW = $clog2(MAX_VERTICES + 1);
   localparam int CAW = $clog2(MAX_ENTRIES);
   localparam int EW  = $clog2(MAX_ENTRIES + 1);
   localparam int XW0 = (RAW > EW) ? RAW : EW;
   localparam int XW  = (XW0 > gis_pkg::VALUE_W) ? XW0 : gis_pkg::VALUE_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_LO,
      S_HI,
      S_BOUNDS,
      S_SCAN_COL,
      S_SCAN_NB,
      S_SCAN_TEST,
      S_MARK_COL,
      S_MARK_WR,
      S_RESPOND
   } state_type;

   logic [gis_pkg::VALUE_W-1:0]  row_mem [MAX_VERTICES+1];
   logic [gis_pkg::VERTEX_W-1:0] col_mem [MAX_ENTRIES];
   logic [gis_pkg::MARK_W-1:0]   mark_mem [MAX_VERTICES];

   state_type                    state_ff, state_in;
   logic [VAW-1:0]               clr_ff, clr_in;
   logic                         clr_reply_ff, clr_reply_in;
   logic [gis_pkg::VERTEX_W-1:0] vtx_ff, vtx_in;
   logic [gis_pkg::VERTEX_W-1:0] echo_ff, echo_in;
   logic [gis_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [gis_pkg::COUNT_W-1:0]  chosen_ff, chosen_in;
   logic [gis_pkg::COUNT_W-1:0]  vcount_ff, vcount_in;
   logic [gis_pkg::VALUE_W-1:0]  lo_raw_ff, lo_raw_in;
   logic [EW-1:0]                k_ff, k_in;
   logic [EW-1:0]                hi_ff, hi_in;
   logic                         nb_ok_ff, nb_ok_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [gis_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [gis_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [gis_pkg::VALUE_W-1:0]  row_q_ff;
   logic [gis_pkg::VERTEX_W-1:0] col_q_ff;
   logic [gis_pkg::MARK_W-1:0]   mark_q_ff;

   logic [gis_pkg::POSITION_W-1:0] req_position;
   logic [gis_pkg::VALUE_W-1:0]    req_value;
   logic [gis_pkg::VERTEX_W-1:0]   req_vertex;
   logic                           req_accept;

   logic                         row_we;
   logic [RAW-1:0]               row_waddr, row_raddr;
   logic                         col_we;
   logic [CAW-1:0]               col_waddr, col_raddr;
   logic                         mark_we;
   logic [VAW-1:0]               mark_waddr, mark_raddr;
   logic [gis_pkg::MARK_W-1:0]   mark_wdata;

   logic [XW-1:0] pos_x, req_vtx_x, vtx_x, vtx1_x, vc_x, nb_x, hi_x, hi_c, lo_x, lo_c, span;
   logic          req_bad, nb_ok, k_last;
   logic [EW-1:0] k_next;

   assign req_position = req_tdata[12:0];
   assign req_value    = req_tdata[26:13];
   assign req_vertex   = req_tdata[36:27];

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      pos_x     = XW'(req_position);
      req_vtx_x = XW'(req_vertex);
      vtx_x     = XW'(vtx_ff);
      vtx1_x    = vtx_x + XW'(1);
      vc_x      = XW'(vcount_ff);
      nb_x      = XW'(col_q_ff);
      req_bad   = (req_vtx_x >= vc_x) || (req_vtx_x >= XW'(MAX_VERTICES));
      nb_ok     = (nb_x != vtx_x) && (nb_x < vc_x) && (nb_x < XW'(MAX_VERTICES));
      hi_x      = XW'(row_q_ff);
      hi_c      = (hi_x > XW'(MAX_ENTRIES)) ? XW'(MAX_ENTRIES) : hi_x;
      lo_x      = XW'(lo_raw_ff);
      lo_c      = (lo_x > hi_c) ? hi_c : lo_x;
      span      = hi_c - lo_c;
      k_next    = k_ff + EW'(1);
      k_last    = (k_next == hi_ff);
   end

   always_comb begin
      row_we     = req_accept && (req_tuser == gis_pkg::MODE_LOAD_ROW)
                   && (pos_x <= XW'(MAX_VERTICES));
      row_waddr  = pos_x[RAW-1:0];
      row_raddr  = (state_ff == S_HI) ? vtx1_x[RAW-1:0] : vtx_x[RAW-1:0];
      col_we     = req_accept && (req_tuser == gis_pkg::MODE_LOAD_COL)
                   && (pos_x < XW'(MAX_ENTRIES));
      col_waddr  = pos_x[CAW-1:0];
      col_raddr  = k_ff[CAW-1:0];
      mark_raddr = (state_ff == S_SCAN_NB) ? nb_x[VAW-1:0] : vtx_x[VAW-1:0];
      mark_we    = 1'b0;
      mark_waddr = vtx_x[VAW-1:0];
      mark_wdata = gis_pkg::MARK_EXCLUDED;
      case (state_ff)
         S_CLEAR: begin
            mark_we    = 1'b1;
            mark_waddr = clr_ff;
            mark_wdata = gis_pkg::MARK_NONE;
         end
         S_BOUNDS: begin
            mark_we = (span < XW'(2));
         end
         S_SCAN_TEST: begin
            if (nb_ok_ff && (mark_q_ff == gis_pkg::MARK_SELECTED)) begin
               mark_we = 1'b1;
            end else if (k_last) begin
               mark_we    = 1'b1;
               mark_wdata = gis_pkg::MARK_SELECTED;
            end
         end
         S_MARK_WR: begin
            mark_we    = nb_ok;
            mark_waddr = nb_x[VAW-1:0];
         end
         default: begin
            mark_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_waddr] <= req_value;
      end
      row_q_ff <= row_mem[row_raddr];
   end

   always_ff @(posedge clock) begin
      if (col_we) begin
         col_mem[col_waddr] <= req_value[gis_pkg::VERTEX_W-1:0];
      end
      col_q_ff <= col_mem[col_raddr];
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_waddr] <= mark_wdata;
      end
      mark_q_ff <= mark_mem[mark_raddr];
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      clr_reply_in  = clr_reply_ff;
      vtx_in        = vtx_ff;
      echo_in       = echo_ff;
      status_in     = status_ff;
      chosen_in     = chosen_ff;
      vcount_in     = vcount_ff;
      lo_raw_in     = lo_raw_ff;
      k_in          = k_ff;
      hi_in         = hi_ff;
      nb_ok_in      = nb_ok_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;

      if (csr_valid && csr_ready) begin
         vcount_in = csr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               vtx_in    = req_vertex;
               echo_in   = '0;
               status_in = gis_pkg::ST_LOADED;
               state_in  = S_RESPOND;
               case (req_tuser)
                  gis_pkg::MODE_VISIT: begin
                     echo_in = req_vertex;
                     if (req_bad) begin
                        status_in = gis_pkg::ST_BAD;
                     end else begin
                        state_in = S_LO;
                     end
                  end
                  gis_pkg::MODE_CLEAR: begin
                     chosen_in    = '0;
                     clr_in       = '0;
                     clr_reply_in = 1'b1;
                     status_in    = gis_pkg::ST_CLEARED;
                     state_in     = S_CLEAR;
                  end
                  default: begin
                     status_in = gis_pkg::ST_LOADED;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            clr_in = clr_ff + VAW'(1);
            if (clr_ff == VAW'(MAX_VERTICES - 1)) begin
               state_in = clr_reply_ff ? S_RESPOND : S_IDLE;
            end
         end
         S_LO: begin
            state_in = S_HI;
         end
         S_HI: begin
            lo_raw_in = row_q_ff;
            if (mark_q_ff != gis_pkg::MARK_NONE) begin
               status_in = gis_pkg::ST_MARKED;
               state_in  = S_RESPOND;
            end else begin
               state_in = S_BOUNDS;
            end
         end
         S_BOUNDS: begin
            k_in  = lo_c[EW-1:0];
            hi_in = hi_c[EW-1:0];
            if (span < XW'(2)) begin
               status_in = gis_pkg::ST_ISOLATED;
               state_in  = S_RESPOND;
            end else begin
               state_in = S_SCAN_COL;
            end
         end
         S_SCAN_COL: begin
            state_in = S_SCAN_NB;
         end
         S_SCAN_NB: begin
            nb_ok_in = nb_ok;
            state_in = S_SCAN_TEST;
         end
         S_SCAN_TEST: begin
            if (nb_ok_ff && (mark_q_ff == gis_pkg::MARK_SELECTED)) begin
               status_in = gis_pkg::ST_NEIGHBOR;
               state_in  = S_RESPOND;
            end else if (k_last) begin
               if (chosen_ff != '1) begin
                  chosen_in = chosen_ff + gis_pkg::COUNT_W'(1);
               end
               k_in     = lo_c[EW-1:0];
               state_in = S_MARK_COL;
            end else begin
               k_in     = k_next;
               state_in = S_SCAN_COL;
            end
         end
         S_MARK_COL: begin
            state_in = S_MARK_WR;
         end
         S_MARK_WR: begin
            k_in = k_next;
            if (k_last) begin
               status_in = gis_pkg::ST_SELECTED;
               state_in  = S_RESPOND;
            end else begin
               state_in = S_MARK_COL;
            end
         end
         S_RESPOND: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_data_in   = {3'b000, chosen_ff, echo_ff};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The row start is clamped again when the second row walk starts; the row end is kept from the first.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         clr_reply_ff <= 1'b0;
         chosen_ff    <= '0;
         vcount_ff    <= gis_pkg::VERTEX_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_reply_ff <= clr_reply_in;
         chosen_ff    <= chosen_in;
         vcount_ff    <= vcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vtx_ff        <= vtx_in;
      echo_ff       <= echo_in;
      status_ff     <= status_in;
      lo_raw_ff     <= lo_raw_in;
      k_ff          <= k_in;
      hi_ff         <= hi_in;
      nb_ok_ff      <= nb_ok_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Testbench for the greedy independent set selector: loads small graphs, visits their
// vertices and checks every response against a behavioural copy of the selector.
// Depends on gis_pkg and greedy_independent_set_selector.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NV = gis_pkg::MAX_VERTICES_DEFAULT;
   localparam int NE = gis_pkg::MAX_ENTRIES_DEFAULT;
   localparam int RANDOM_ITEMS = 1050;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [gis_pkg::STATUS_W-1:0] status;
      logic [gis_pkg::VERTEX_W-1:0] vertex;
      logic [gis_pkg::COUNT_W-1:0]  count;
   } gis_resp_type;

   typedef struct packed {
      bit           typed;
      gis_resp_type r;
   } typed_answer_type;

   typedef struct packed {
      logic [gis_pkg::MODE_W-1:0]     mode;
      logic [gis_pkg::POSITION_W-1:0] pos;
      logic [gis_pkg::VALUE_W-1:0]    val;
      logic [gis_pkg::VERTEX_W-1:0]   vtx;
      bit                             typed;
      logic [gis_pkg::STATUS_W-1:0]   status;
      logic [gis_pkg::VERTEX_W-1:0]   vout;
      logic [gis_pkg::COUNT_W-1:0]    cnt;
   } plan_row_type;

   // A four-vertex graph: 0 has its diagonal only, 1 links to 2 and 3, 2 links to 1,
   // 3 links to an id outside the vertex count.
   localparam plan_row_type DIRECTED [25] = '{
      '{gis_pkg::MODE_LOAD_ROW, 13'd0, 14'd0, 10'd0, 1'b1, gis_pkg::ST_LOADED, 10'd0, 11'd0},
      '{gis_pkg::MODE_LOAD_ROW, 13'd1, 14'd1, 10'h3FF, 1'b1, gis_pkg::ST_LOADED, 10'd0, 11'd0},
      '{gis_pkg::MODE_LOAD_ROW, 13'd2, 14'd4, 10'd0, 1'b1, gis_pkg::ST_LOADED, 10'd0, 11'd0},
      '{gis_pkg::MODE_LOAD_ROW, 13'd3, 14'd6, 10'd0, 1'b1, gis_pkg::ST_LOADED, 10'd0, 11'd0},
      '{gis_pkg::MODE_LOAD_ROW, 13'd4, 14'd8, 10'd0, 1'b1, gis_pkg::ST_LOADED, 10'd0, 11'd0},
      '{gis_pkg::MODE_LOAD_COL, 13'd0, 14'd0, 10'd0, 1'b1, gis_pkg::ST_LOADED, 10'd0, 11'd0},
      '{gis_pkg::MODE_LOAD_COL, 13'd1, 14'd1, 10'd0, 1'b1, gis_pkg::ST_LOADED, 10'd0, 11'd0},
      '{gis_pkg::MODE_LOAD_COL, 13'd2, 14'd2, 10'd0, 1'b1, gis_pkg::ST_LOADED, 10'd0, 11'd0},
      '{gis_pkg::MODE_LOAD_COL, 13'd3, 14'd3, 10'd0, 1'b1, gis_pkg::ST_LOADED, 10'd0, 11'd0},
      '{gis_pkg::MODE_LOAD_COL, 13'd4, 14'd2, 10'd0, 1'b1, gis_pkg::ST_LOADED, 10'd0, 11'd0},
      '{gis_pkg::MODE_LOAD_COL, 13'd5, 14'd1, 10'd0, 1'b1, gis_pkg::ST_LOADED, 10'd0, 11'd0},
      '{gis_pkg::MODE_LOAD_COL, 13'd6, 14'd3, 10'd0, 1'b1, gis_pkg::ST_LOADED, 10'd0, 11'd0},
      '{gis_pkg::MODE_LOAD_COL, 13'd7, 14'h3FFF, 10'd0, 1'b1, gis_pkg::ST_LOADED, 10'd0,
        11'd0},
      '{gis_pkg::MODE_LOAD_ROW, 13'h1FFF, 14'h3FFF, 10'h3FF, 1'b1, gis_pkg::ST_LOADED, 10'd0,
        11'd0},
      '{gis_pkg::MODE_LOAD_COL, 13'h1FFF, 14'h2AAA, 10'h155, 1'b1, gis_pkg::ST_LOADED, 10'd0,
        11'd0},
      '{gis_pkg::MODE_VISIT, 13'h1FFF, 14'h3FFF, 10'h3FF, 1'b1, gis_pkg::ST_BAD, 10'h3FF,
        11'd0},
      '{gis_pkg::MODE_VISIT, 13'd0, 14'd0, 10'd0, 1'b1, gis_pkg::ST_ISOLATED, 10'd0, 11'd0},
      '{gis_pkg::MODE_VISIT, 13'd0, 14'd0, 10'd0, 1'b1, gis_pkg::ST_MARKED, 10'd0, 11'd0},
      '{gis_pkg::MODE_VISIT, 13'd0, 14'd0, 10'd1, 1'b1, gis_pkg::ST_SELECTED, 10'd1, 11'd1},
      '{gis_pkg::MODE_VISIT, 13'd0, 14'd0, 10'd2, 1'b1, gis_pkg::ST_MARKED, 10'd2, 11'd1},
      '{gis_pkg::MODE_CLEAR, 13'h1FFF, 14'h3FFF, 10'h3FF, 1'b1, gis_pkg::ST_CLEARED, 10'd0,
        11'd0},
      '{gis_pkg::MODE_VISIT, 13'd0, 14'd0, 10'd3, 1'b1, gis_pkg::ST_SELECTED, 10'd3, 11'd1},
      '{gis_pkg::MODE_VISIT, 13'd0, 14'd0, 10'd1, 1'b0, gis_pkg::ST_LOADED, 10'd0, 11'd0},
      '{gis_pkg::MODE_VISIT, 13'd0, 14'd0, 10'd2, 1'b0, gis_pkg::ST_LOADED, 10'd0, 11'd0},
      '{gis_pkg::MODE_VISIT, 13'd0, 14'd0, 10'd4, 1'b1, gis_pkg::ST_BAD, 10'd4, 11'd2}
   };

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic [gis_pkg::REQ_DATA_W-1:0]   req_tdata = '0;
   logic [gis_pkg::MODE_W-1:0]       req_tuser = '0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [gis_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic [gis_pkg::STATUS_W-1:0]     rsp_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [gis_pkg::COUNT_W-1:0]      csr_data = '0;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;

   logic [gis_pkg::VALUE_W-1:0]  row_offsets [0:NV];
   logic [gis_pkg::VERTEX_W-1:0] col_ids [0:NE-1];
   bit                           row_known [0:NV];
   bit                           col_known [0:NE-1];
   logic [gis_pkg::MARK_W-1:0]   marks [0:NV-1];
   logic [gis_pkg::COUNT_W-1:0]  chosen = '0;
   logic [gis_pkg::COUNT_W-1:0]  vcount = gis_pkg::VERTEX_COUNT_RESET;

   gis_resp_type     answers_due [$];
   typed_answer_type table_answers [$];
   int               fail_count = 0;
   int               cycle_count = 0;
   int               items_sent = 0;
   int               send_idle = 36;
   int               recv_idle = 48;
   int               send_calm = 0;
   int               recv_calm = 0;

   greedy_independent_set_selector DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      foreach (marks[i]) marks[i] = gis_pkg::MARK_NONE;
   end

   function automatic bit vertex_in_use(input int v);
      return (v < NV) && (v < int'(vcount));
   endfunction

   function automatic logic [gis_pkg::STATUS_W-1:0] visit_vertex(input int v);
      int lo;
      int hi;
      int k;
      int nb;
      if (!vertex_in_use(v)) return gis_pkg::ST_BAD;
      if (marks[v] != gis_pkg::MARK_NONE) return gis_pkg::ST_MARKED;
      hi = int'(row_offsets[v + 1]);
      lo = int'(row_offsets[v]);
      if (hi > NE) hi = NE;
      if (lo > hi) lo = hi;
      if (hi - lo < 2) begin
         marks[v] = gis_pkg::MARK_EXCLUDED;
         return gis_pkg::ST_ISOLATED;
      end
      for (k = lo; k < hi; k++) begin
         nb = int'(col_ids[k]);
         if (nb != v && vertex_in_use(nb) && marks[nb] == gis_pkg::MARK_SELECTED) begin
            marks[v] = gis_pkg::MARK_EXCLUDED;
            return gis_pkg::ST_NEIGHBOR;
         end
      end
      marks[v] = gis_pkg::MARK_SELECTED;
      if (chosen != 11'd2047) chosen = chosen + 11'd1;
      for (k = lo; k < hi; k++) begin
         nb = int'(col_ids[k]);
         if (nb != v && vertex_in_use(nb)) marks[nb] = gis_pkg::MARK_EXCLUDED;
      end
      return gis_pkg::ST_SELECTED;
   endfunction

   function automatic gis_resp_type next_answer(input logic [gis_pkg::MODE_W-1:0] mode,
                                                input logic [gis_pkg::POSITION_W-1:0] pos,
                                                input logic [gis_pkg::VALUE_W-1:0] val,
                                                input logic [gis_pkg::VERTEX_W-1:0] vtx);
      gis_resp_type a;
      a.status = gis_pkg::ST_LOADED;
      a.vertex = '0;
      case (mode)
         gis_pkg::MODE_LOAD_ROW: begin
            if (int'(pos) <= NV) begin
               row_offsets[pos] = val;
               row_known[pos] = 1'b1;
            end
         end
         gis_pkg::MODE_LOAD_COL: begin
            if (int'(pos) < NE) begin
               col_ids[pos] = val[gis_pkg::VERTEX_W-1:0];
               col_known[pos] = 1'b1;
            end
         end
         gis_pkg::MODE_VISIT: begin
            a.vertex = vtx;
            a.status = visit_vertex(int'(vtx));
         end
         default: begin
            foreach (marks[i]) marks[i] = gis_pkg::MARK_NONE;
            chosen = '0;
            a.status = gis_pkg::ST_CLEARED;
         end
      endcase
      a.count = chosen;
      return a;
   endfunction

   // A visit may only touch store entries that have been written; long rows are avoided
   // to keep the run short.
   function automatic bit visit_allowed(input int v);
      int lo;
      int hi;
      int k;
      if (!vertex_in_use(v)) return 1'b1;
      if (!row_known[v] || !row_known[v + 1]) return 1'b0;
      hi = int'(row_offsets[v + 1]);
      lo = int'(row_offsets[v]);
      if (hi > NE) hi = NE;
      if (lo > hi) lo = hi;
      if (hi - lo > 40) return 1'b0;
      for (k = lo; k < hi; k++) begin
         if (!col_known[k]) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic send_req(input logic [gis_pkg::MODE_W-1:0] mode,
                           input logic [gis_pkg::POSITION_W-1:0] pos,
                           input logic [gis_pkg::VALUE_W-1:0] val,
                           input logic [gis_pkg::VERTEX_W-1:0] vtx);
      @(negedge clock);
      if (send_calm > 0) begin
         send_calm--;
      end else begin
         if ($urandom_range(99) < 3) send_calm = $urandom_range(20, 60);
         while ($urandom_range(99) < send_idle) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tuser <= mode;
      req_tdata <= {3'b000, vtx, val, pos};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_clear();
      send_req(gis_pkg::MODE_CLEAR, gis_pkg::POSITION_W'($urandom),
               gis_pkg::VALUE_W'($urandom), gis_pkg::VERTEX_W'($urandom));
   endtask

   task automatic send_visit(input int v, input int base, input int n);
      int w;
      w = v;
      if (!visit_allowed(w)) w = base + $urandom_range(n - 1);
      if (visit_allowed(w)) begin
         send_req(gis_pkg::MODE_VISIT, gis_pkg::POSITION_W'($urandom),
                  gis_pkg::VALUE_W'($urandom), gis_pkg::VERTEX_W'(w));
      end else begin
         send_clear();
      end
   endtask

   task automatic set_vertex_count(input logic [gis_pkg::COUNT_W-1:0] n);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (answers_due.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_data <= n;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Rows of vertices base .. base+n-1 go to a contiguous run of column entries; with
   // tail_clamp the run ends at the top of the column store and the last row end is
   // written at or above it.
   task automatic load_graph(input int base, input int n, input bit tail_clamp);
      int deg [0:63];
      int total;
      int cb;
      int off;
      int i;
      int j;
      int r;
      int u;
      logic [gis_pkg::VALUE_W-1:0] cval;
      total = 0;
      for (i = 0; i < n; i++) begin
         deg[i] = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 5);
         total += deg[i];
      end
      if (tail_clamp) cb = NE - total;
      else if ($urandom_range(3) == 0) cb = 0;
      else cb = $urandom_range(NE - total);
      off = cb;
      for (i = 0; i < n; i++) begin
         send_req(gis_pkg::MODE_LOAD_ROW, gis_pkg::POSITION_W'(base + i),
                  gis_pkg::VALUE_W'(off), gis_pkg::VERTEX_W'($urandom));
         off += deg[i];
      end
      if (tail_clamp) begin
         send_req(gis_pkg::MODE_LOAD_ROW, gis_pkg::POSITION_W'(base + n),
                  gis_pkg::VALUE_W'($urandom_range(NE, 16383)), gis_pkg::VERTEX_W'($urandom));
      end else begin
         send_req(gis_pkg::MODE_LOAD_ROW, gis_pkg::POSITION_W'(base + n),
                  gis_pkg::VALUE_W'(off), gis_pkg::VERTEX_W'($urandom));
      end
      off = cb;
      for (i = 0; i < n; i++) begin
         for (j = 0; j < deg[i]; j++) begin
            r = $urandom_range(99);
            if (j == 0 && r < 80) cval = gis_pkg::VALUE_W'(base + i);
            else if (r < 80) cval = gis_pkg::VALUE_W'(base + $urandom_range(n - 1));
            else if (r < 92) cval = gis_pkg::VALUE_W'($urandom_range(1023));
            else cval = gis_pkg::VALUE_W'($urandom);
            send_req(gis_pkg::MODE_LOAD_COL, gis_pkg::POSITION_W'(off), cval,
                     gis_pkg::VERTEX_W'($urandom));
            off++;
         end
      end
      // Raising one row start above the next makes that row start past its end.
      if (n >= 3 && $urandom_range(3) == 0) begin
         u = $urandom_range(1, n - 1);
         send_req(gis_pkg::MODE_LOAD_ROW, gis_pkg::POSITION_W'(base + u),
                  gis_pkg::VALUE_W'(int'(row_offsets[base + u + 1]) + $urandom_range(1, 3)),
                  gis_pkg::VERTEX_W'($urandom));
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (recv_calm > 0) begin
         recv_calm <= recv_calm - 1;
         rsp_tready <= 1'b1;
      end else begin
         if ($urandom_range(99) < 2) recv_calm <= $urandom_range(20, 80);
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      gis_resp_type     got;
      gis_resp_type     want;
      typed_answer_type hint;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end else if (!reset) begin
         if (csr_valid && csr_ready) vcount = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser;
            got.vertex = rsp_tdata[9:0];
            got.count = rsp_tdata[20:10];
            if (answers_due.size() == 0) begin
               $error("response transaction with no request waiting: status %0d", got.status);
               fail_count++;
            end else begin
               want = answers_due.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  fail_count++;
               end
               if (got.vertex !== want.vertex) begin
                  $error("vertex_out: expected %0d, got %0d", want.vertex, got.vertex);
                  fail_count++;
               end
               if (got.count !== want.count) begin
                  $error("selected_count: expected %0d, got %0d", want.count, got.count);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            want = next_answer(req_tuser, req_tdata[12:0], req_tdata[26:13], req_tdata[36:27]);
            if (table_answers.size() != 0) begin
               hint = table_answers.pop_front();
               if (hint.typed) want = hint.r;
            end
            answers_due.push_back(want);
         end
      end
   end

   initial begin
      typed_answer_type row_answer;
      int ep;
      int n;
      int base;
      int nv;
      int r;
      int k;
      int visits;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_vertex_count(11'd4);
      foreach (DIRECTED[i]) begin
         row_answer.typed = DIRECTED[i].typed;
         row_answer.r.status = DIRECTED[i].status;
         row_answer.r.vertex = DIRECTED[i].vout;
         row_answer.r.count = DIRECTED[i].cnt;
         table_answers.push_back(row_answer);
         send_req(DIRECTED[i].mode, DIRECTED[i].pos, DIRECTED[i].val, DIRECTED[i].vtx);
      end

      items_sent = 0;
      ep = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent < RANDOM_ITEMS / 3) begin
            send_idle = 36;
            recv_idle = 48;
         end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
            send_idle = 48;
            recv_idle = 36;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         n = ($urandom_range(15) == 0) ? 48 : $urandom_range(3, 24);
         r = $urandom_range(9);
         if (ep == 1 || r == 0) begin
            base = 0;
            nv = 1;
         end else begin
            k = $urandom_range(3);
            if (k == 0) base = 0;
            else if (k == 1) base = NV - n;
            else base = $urandom_range(NV - n);
            if (ep == 0 || r <= 5) nv = NV;
            else nv = base + $urandom_range(n / 2, n + 3);
            if (nv > NV) nv = NV;
         end
         set_vertex_count(gis_pkg::COUNT_W'(nv));
         if ($urandom_range(1) == 0) send_clear();
         load_graph(base, n, $urandom_range(4) == 0);
         visits = 2 * n + $urandom_range(n);
         repeat (visits) begin
            if (items_sent >= RANDOM_ITEMS) break;
            r = $urandom_range(99);
            if (r < 5) begin
               send_req(gis_pkg::MODE_LOAD_ROW,
                        gis_pkg::POSITION_W'($urandom_range(NV + 1, 8191)),
                        gis_pkg::VALUE_W'($urandom), gis_pkg::VERTEX_W'($urandom));
            end else if (r < 9) begin
               send_req(gis_pkg::MODE_LOAD_COL, gis_pkg::POSITION_W'($urandom),
                        gis_pkg::VALUE_W'($urandom), gis_pkg::VERTEX_W'($urandom));
            end else if (r < 12) begin
               send_clear();
            end else if (r < 22) begin
               send_visit($urandom_range(1023), base, n);
            end else begin
               send_visit(base + $urandom_range(n - 1), base, n);
            end
         end
         ep++;
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (answers_due.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end
endmodule
